[rtl/core/stwag_pkg.sv]
// Shared types, widths and element-size decode for the strided tensor walk
// address generator. No dependencies; used by the files in rtl/core but stwag_odo_cell.
`timescale 1ns / 1ps

package stwag_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_DIMS = 4;
    localparam int DEF_DIM_BITS = 16;

    // Fixed field and register widths
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int LANE_W     = 16;
    localparam int PSTRIDE_W  = 32;
    localparam int NDIM_W     = 3;
    localparam int ETYPE_W    = 4;
    localparam int OFF_W      = 54;
    localparam int DST_W      = 64;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_DIMS     = 3'd0,
        CFG_DIM_SIZES    = 3'd1,
        CFG_VIEW_ENABLE  = 3'd2,
        CFG_VIEW_STARTS  = 3'd3,
        CFG_STRIDES_LOW  = 3'd4,
        CFG_STRIDES_HIGH = 3'd5,
        CFG_ELEM_TYPE    = 3'd6
    } t_cfg_idx;

    // Element type codes
    typedef enum logic [ETYPE_W-1:0] {
        ET_BOOL = 4'd0,
        ET_U8   = 4'd1,
        ET_U16  = 4'd2,
        ET_U32  = 4'd3,
        ET_U64  = 4'd4,
        ET_I8   = 4'd5,
        ET_I16  = 4'd6,
        ET_I32  = 4'd7,
        ET_I64  = 4'd8,
        ET_F16  = 4'd9,
        ET_F32  = 4'd10,
        ET_F64  = 4'd11
    } t_elem_type;

    // Element size as a shift; known is low for undefined codes (size 0)
    typedef struct packed {
        logic       known;
        logic [1:0] shift;
    } t_scale;

    // Per-item tag carried down the cell chain
    typedef struct packed {
        logic             valid;
        logic             last_element;
        logic [DST_W-1:0] dst_index;
    } t_tag;

    // Element size decode: 1, 2, 4 or 8 bytes; f16 is stored in 4 bytes
    function automatic t_scale elem_scale(logic [ETYPE_W-1:0] code);
        t_scale s;
        s.known = 1'b1;
        s.shift = 2'd0;
        unique case (code) inside
            ET_BOOL, ET_U8, ET_I8:          s.shift = 2'd0;
            ET_U16, ET_I16:                 s.shift = 2'd1;
            ET_U32, ET_I32, ET_F16, ET_F32: s.shift = 2'd2;
            ET_U64, ET_I64, ET_F64:         s.shift = 2'd3;
            default: begin
                s.known = 1'b0;
                s.shift = 2'd0;
            end
        endcase
        return s;
    endfunction

endpackage

[rtl/core/strided_tensor_walk_address_gen_unit.sv]
// Path: an accepted item passes through the registered offset cells, then the output
// register that adds the last term and scales.
// Throughput: one item per cycle; the odometer advances in the accept cycle and
// the offset chain is fully pipelined. A stalled output holds the whole chain.
// Reset (synchronous, active low): coordinates, destination index and valid flags go to
// zero, num_dims and dim_sizes to 1, other config registers to zero. No clearing pass.
`timescale 1ns / 1ps

module strided_tensor_walk_address_gen_unit #(
    parameter int MAX_DIMS = stwag_pkg::DEF_MAX_DIMS,
    parameter int DIM_BITS = stwag_pkg::DEF_DIM_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // item input
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_restart,
    // result output
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [stwag_pkg::OFF_W-1:0]        o_src_byte_offset,
    output logic [stwag_pkg::DST_W-1:0]        o_dst_index,
    output logic                               o_last_element,
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [stwag_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [stwag_pkg::CFG_W-1:0]        i_cfg_wdata
);

    localparam int CONTIG_W = (MAX_DIMS - 1) * DIM_BITS;
    localparam int STRIDE_W = (CONTIG_W > stwag_pkg::PSTRIDE_W) ? CONTIG_W
                                                                 : stwag_pkg::PSTRIDE_W;
    localparam int OFF_W    = stwag_pkg::OFF_W;
    localparam int DST_W    = stwag_pkg::DST_W;
    localparam int NDIM_W   = stwag_pkg::NDIM_W;

    // Configuration registers
    logic [NDIM_W-1:0]               r_num_dims;
    logic [stwag_pkg::CFG_W-1:0]     r_dim_sizes;
    logic                            r_view_en;
    logic [stwag_pkg::CFG_W-1:0]     r_view_starts;
    logic [stwag_pkg::CFG_W-1:0]     r_strides_lo;
    logic [stwag_pkg::CFG_W-1:0]     r_strides_hi;
    logic [stwag_pkg::ETYPE_W-1:0]   r_elem_type;

    // Walk state and output register
    logic [DST_W-1:0]                r_dest;
    logic [DST_W-1:0]                n_dest;
    logic                            r_out_valid;
    logic [OFF_W-1:0]                r_out_off;
    logic [DST_W-1:0]                r_out_dst;
    logic                            r_out_last;

    logic                            w_en;
    logic                            w_accept;
    logic [NDIM_W-1:0]               w_n;
    logic                            w_scalar;
    logic                            w_last;
    logic [DST_W-1:0]                w_dest_eff;
    logic [OFF_W-1:0]                w_off_sum;
    logic [OFF_W-1:0]                w_off;
    stwag_pkg::t_scale               w_scale;

    logic [MAX_DIMS-1:0]                   w_active;
    logic [DIM_BITS-1:0]                   w_size   [MAX_DIMS];
    logic [DIM_BITS-1:0]                   w_start  [MAX_DIMS];
    logic [stwag_pkg::PSTRIDE_W-1:0]       w_parent [MAX_DIMS];
    logic [MAX_DIMS:0]                     w_carry;

    // Offset chain: index d+1 feeds cell d, index MAX_DIMS is the entry
    stwag_pkg::t_tag                       w_tag    [MAX_DIMS+1];
    logic [OFF_W-1:0]                      w_sum    [MAX_DIMS+1];
    logic [OFF_W-1:0]                      w_prod   [MAX_DIMS+1];
    logic [STRIDE_W-1:0]                   w_stride [MAX_DIMS+1];
    logic [MAX_DIMS-1:0][DIM_BITS-1:0]     w_coords [MAX_DIMS+1];

    // Handshake: everything moves unless a finished result is held
    assign w_en       = !(r_out_valid && i_out_stall);
    assign o_in_stall = !w_en;
    assign w_accept   = i_in_valid && w_en;

    // Configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims    <= NDIM_W'(1);
            r_dim_sizes   <= stwag_pkg::CFG_W'(1);
            r_view_en     <= 1'b0;
            r_view_starts <= '0;
            r_strides_lo  <= '0;
            r_strides_hi  <= '0;
            r_elem_type   <= '0;
        end else if (i_cfg_we) begin
            unique case (stwag_pkg::t_cfg_idx'(i_cfg_index))
                stwag_pkg::CFG_NUM_DIMS:     r_num_dims    <= i_cfg_wdata[NDIM_W-1:0];
                stwag_pkg::CFG_DIM_SIZES:    r_dim_sizes   <= i_cfg_wdata;
                stwag_pkg::CFG_VIEW_ENABLE:  r_view_en     <= i_cfg_wdata[0];
                stwag_pkg::CFG_VIEW_STARTS:  r_view_starts <= i_cfg_wdata;
                stwag_pkg::CFG_STRIDES_LOW:  r_strides_lo  <= i_cfg_wdata;
                stwag_pkg::CFG_STRIDES_HIGH: r_strides_hi  <= i_cfg_wdata;
                stwag_pkg::CFG_ELEM_TYPE:
                    r_elem_type <= i_cfg_wdata[stwag_pkg::ETYPE_W-1:0];
                default: ;
            endcase
        end
    end

    // Active dimension count, capped at MAX_DIMS
    assign w_n      = (r_num_dims > NDIM_W'(MAX_DIMS)) ? NDIM_W'(MAX_DIMS) : r_num_dims;
    assign w_scalar = (w_n == '0);

    // Innermost digit always sees a carry
    assign w_carry[MAX_DIMS] = 1'b1;

    // Per-dimension lanes, odometer digits and offset cells
    for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
        localparam int LANE_POS = stwag_pkg::CFG_W - stwag_pkg::LANE_W * (d + 1);
        localparam int PS_POS   = ((d % 2) == 0) ? stwag_pkg::PSTRIDE_W : 0;

        assign w_active[d] = (NDIM_W'(d) < w_n);
        assign w_size[d]   = r_dim_sizes[LANE_POS +: DIM_BITS];
        assign w_start[d]  = r_view_starts[LANE_POS +: DIM_BITS];
        assign w_parent[d] = (d < 2) ? r_strides_lo[PS_POS +: stwag_pkg::PSTRIDE_W]
                                     : r_strides_hi[PS_POS +: stwag_pkg::PSTRIDE_W];

        stwag_odo_cell #(
            .DIM_BITS (DIM_BITS)
        ) u_odo (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_step    (w_accept),
            .i_restart (i_restart),
            .i_active  (w_active[d]),
            .i_size    (w_size[d]),
            .i_carry   (w_carry[d+1]),
            .o_carry   (w_carry[d]),
            .o_coord   (w_coords[MAX_DIMS][d])
        );

        stwag_term_cell #(
            .MAX_DIMS (MAX_DIMS),
            .DIM_BITS (DIM_BITS),
            .STRIDE_W (STRIDE_W),
            .CELL_IDX (d)
        ) u_term (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_active  (w_active[d]),
            .i_view_en (r_view_en),
            .i_start   (w_start[d]),
            .i_parent  (w_parent[d]),
            .i_size    (w_size[d]),
            .i_tag     (w_tag[d+1]),
            .i_sum     (w_sum[d+1]),
            .i_prod    (w_prod[d+1]),
            .i_stride  (w_stride[d+1]),
            .i_coords  (w_coords[d+1]),
            .o_tag     (w_tag[d]),
            .o_sum     (w_sum[d]),
            .o_prod    (w_prod[d]),
            .o_stride  (w_stride[d]),
            .o_coords  (w_coords[d])
        );
    end

    // Last element: every active digit wraps
    assign w_last     = w_carry[0];
    assign w_dest_eff = i_restart ? '0 : r_dest;

    // Destination counter; a scalar walk leaves it alone
    always_comb begin
        if (w_scalar) begin
            n_dest = w_dest_eff;
        end else if (w_last) begin
            n_dest = '0;
        end else begin
            n_dest = w_dest_eff + DST_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest <= '0;
        end else if (w_accept) begin
            r_dest <= n_dest;
        end
    end

    // Chain entry
    assign w_tag[MAX_DIMS].valid        = w_accept;
    assign w_tag[MAX_DIMS].last_element = w_last;
    assign w_tag[MAX_DIMS].dst_index    = w_scalar ? '0 : w_dest_eff;
    assign w_sum[MAX_DIMS]              = '0;
    assign w_prod[MAX_DIMS]             = '0;
    assign w_stride[MAX_DIMS]           = STRIDE_W'(1);

    // Final fold and element-size scaling
    assign w_off_sum = w_sum[0] + w_prod[0];
    assign w_scale   = stwag_pkg::elem_scale(r_elem_type);
    assign w_off     = w_scale.known ? (w_off_sum << w_scale.shift) : '0;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_tag[0].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_tag[0].valid) begin
            r_out_off  <= w_off;
            r_out_dst  <= w_tag[0].dst_index;
            r_out_last <= w_tag[0].last_element;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_src_byte_offset = r_out_off;
    assign o_dst_index       = r_out_dst;
    assign o_last_element    = r_out_last;

    // Checks on the walk state
    a_dest_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && w_accept && !i_restart && !w_last && !w_scalar)
        |=> (r_dest == $past(r_dest) + DST_W'(1)))
        else $error("destination index did not advance by one");

    a_dest_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && w_accept && w_last && !w_scalar) |=> (r_dest == '0))
        else $error("destination index did not wrap after last element");

    a_dest_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !w_accept) |=> $stable(r_dest))
        else $error("destination index moved without an item");

endmodule

[rtl/core/stwag_odo_cell.sv]
// One digit of the coordinate odometer: holds a dimension's coordinate and
// passes its carry to the next outer dimension. Depends on nothing.
`timescale 1ns / 1ps

module stwag_odo_cell #(
    parameter int DIM_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_restart,
    input  logic                i_active,
    input  logic [DIM_BITS-1:0] i_size,
    input  logic                i_carry,
    output logic                o_carry,
    output logic [DIM_BITS-1:0] o_coord
);

    logic [DIM_BITS-1:0] r_coord;
    logic [DIM_BITS-1:0] n_coord;
    logic [DIM_BITS-1:0] w_eff;
    logic [DIM_BITS:0]   w_inc;
    logic                w_wrap;

    // Restart zeroes the coordinate before the item is used
    assign w_eff   = i_restart ? '0 : r_coord;
    assign w_inc   = {1'b0, w_eff} + (DIM_BITS + 1)'(1);
    // Size zero or a coordinate past the size wraps at once
    assign w_wrap  = (w_inc >= {1'b0, i_size});
    // Inactive digits pass the carry through untouched
    assign o_carry = i_carry & (~i_active | w_wrap);
    assign o_coord = w_eff;

    // Next coordinate
    always_comb begin
        if (i_active && i_carry) begin
            n_coord = w_wrap ? '0 : w_inc[DIM_BITS-1:0];
        end else begin
            n_coord = w_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coord <= '0;
        end else if (i_step) begin
            r_coord <= n_coord;
        end
    end

endmodule

[rtl/core/stwag_term_cell.sv]
// One stage of the offset chain: forms coordinate * stride for its dimension, or
// (coordinate + start) * parent stride in view mode, and the next contiguous stride,
// and folds in the previous term. Depends on stwag_pkg.
`timescale 1ns / 1ps

module stwag_term_cell #(
    parameter int MAX_DIMS = stwag_pkg::DEF_MAX_DIMS,
    parameter int DIM_BITS = stwag_pkg::DEF_DIM_BITS,
    parameter int STRIDE_W = 48,
    parameter int CELL_IDX = 0
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_active,
    input  logic                                 i_view_en,
    input  logic [DIM_BITS-1:0]                  i_start,
    input  logic [stwag_pkg::PSTRIDE_W-1:0]      i_parent,
    input  logic [DIM_BITS-1:0]                  i_size,
    input  stwag_pkg::t_tag                      i_tag,
    input  logic [stwag_pkg::OFF_W-1:0]          i_sum,
    input  logic [stwag_pkg::OFF_W-1:0]          i_prod,
    input  logic [STRIDE_W-1:0]                  i_stride,
    input  logic [MAX_DIMS-1:0][DIM_BITS-1:0]    i_coords,
    output stwag_pkg::t_tag                      o_tag,
    output logic [stwag_pkg::OFF_W-1:0]          o_sum,
    output logic [stwag_pkg::OFF_W-1:0]          o_prod,
    output logic [STRIDE_W-1:0]                  o_stride,
    output logic [MAX_DIMS-1:0][DIM_BITS-1:0]    o_coords
);

    localparam int CW     = DIM_BITS + 1;
    localparam int MUL_W  = CW + STRIDE_W;
    localparam int SMUL_W = STRIDE_W + DIM_BITS;

    stwag_pkg::t_tag                   r_tag;
    logic [stwag_pkg::OFF_W-1:0]       r_sum;
    logic [stwag_pkg::OFF_W-1:0]       r_prod;
    logic [STRIDE_W-1:0]               r_stride;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0] r_coords;

    logic [CW-1:0]                     w_coord;
    logic [STRIDE_W-1:0]               w_s;
    logic [MUL_W-1:0]                  w_mul;
    logic [SMUL_W-1:0]                 w_smul;
    logic [stwag_pkg::OFF_W-1:0]       n_sum;
    logic [stwag_pkg::OFF_W-1:0]       n_prod;
    logic [STRIDE_W-1:0]               n_stride;

    // Term of this dimension
    assign w_coord = {1'b0, i_coords[CELL_IDX]} + (i_view_en ? {1'b0, i_start} : '0);
    assign w_s     = i_view_en ? STRIDE_W'(i_parent) : i_stride;
    assign w_mul   = w_coord * w_s;
    assign n_prod  = i_active ? stwag_pkg::OFF_W'(w_mul) : '0;

    // Contiguous stride for the next outer dimension
    assign w_smul   = i_stride * i_size;
    assign n_stride = i_active ? STRIDE_W'(w_smul) : i_stride;

    // Fold in the term from the previous cell (wraps mod 2^54)
    assign n_sum = i_sum + i_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum    <= n_sum;
            r_prod   <= n_prod;
            r_stride <= n_stride;
            r_coords <= i_coords;
        end
    end

    assign o_tag    = r_tag;
    assign o_sum    = r_sum;
    assign o_prod   = r_prod;
    assign o_stride = r_stride;
    assign o_coords = r_coords;

endmodule

[test/tb_top.sv]
// Self-checking testbench for the strided tensor walk address generator.
// Depends on stwag_pkg and strided_tensor_walk_address_gen_unit; a built-in walk
// predictor checks each result while both handshakes idle and stall at random.
`timescale 1ns / 1ps

module tb_top;

    localparam int DEF_MAX_DIMS = stwag_pkg::DEF_MAX_DIMS;
    localparam int DEF_DIM_BITS = stwag_pkg::DEF_DIM_BITS;
    localparam int CFG_W        = stwag_pkg::CFG_W;
    localparam int CFG_IDX_W    = stwag_pkg::CFG_IDX_W;
    localparam int LANE_W       = stwag_pkg::LANE_W;
    localparam int NDIM_W       = stwag_pkg::NDIM_W;
    localparam int ETYPE_W      = stwag_pkg::ETYPE_W;
    localparam int OFF_W        = stwag_pkg::OFF_W;
    localparam int DST_W        = stwag_pkg::DST_W;

    localparam int PIPE_LAT  = DEF_MAX_DIMS + 1;
    localparam int RUN_LIMIT = 200000;
    localparam int N_PHASES  = 16;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS     = stwag_pkg::CFG_NUM_DIMS;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZES    = stwag_pkg::CFG_DIM_SIZES;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_ENABLE  = stwag_pkg::CFG_VIEW_ENABLE;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_STARTS  = stwag_pkg::CFG_VIEW_STARTS;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDES_LOW  = stwag_pkg::CFG_STRIDES_LOW;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDES_HIGH = stwag_pkg::CFG_STRIDES_HIGH;
    localparam logic [CFG_IDX_W-1:0] REG_ELEM_TYPE    = stwag_pkg::CFG_ELEM_TYPE;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED     = 3'd7;

    typedef struct {
        logic [OFF_W-1:0] offset;
        logic [DST_W-1:0] dst;
        logic             last;
    } t_walk_result;

    // DUT connections
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 in_restart = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [OFF_W-1:0]     res_offset;
    logic [DST_W-1:0]     res_dst;
    logic                 res_last;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // Predictor copy of the registers and walk state
    logic [NDIM_W-1:0]  m_num_dims = 3'd1;
    logic [CFG_W-1:0]   m_dim_sizes = 64'd1;
    logic               m_view_en = 1'b0;
    logic [CFG_W-1:0]   m_view_starts = '0;
    logic [CFG_W-1:0]   m_str_lo = '0;
    logic [CFG_W-1:0]   m_str_hi = '0;
    logic [ETYPE_W-1:0] m_elem_type = '0;
    logic [LANE_W-1:0]  m_coord [4] = '{default: '0};
    logic [DST_W-1:0]   m_dest = '0;

    // Stimulus and expected results
    logic         restart_queue [$];
    t_walk_result pending_results [$];

    int  err_count = 0;
    int  n_items = 0;
    int  n_results = 0;
    int  n_last = 0;
    int  cycle_count = 0;
    bit  took_item = 1'b0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  stall_mode = 0;
    int  stall_left = 0;

    strided_tensor_walk_address_gen_unit dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_restart         (in_restart),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_src_byte_offset (res_offset),
        .o_dst_index       (res_dst),
        .o_last_element    (res_last),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_wdata       (cfg_wdata)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic logic [CFG_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // One 16-bit lane, dimension 0 in the top bits
    function automatic logic [63:0] lane_of(input logic [CFG_W-1:0] w, input int d);
        logic [LANE_W-1:0] v;
        v = w[63 - 16*d -: 16];
        return 64'(v & LANE_W'((1 << DEF_DIM_BITS) - 1));
    endfunction

    function automatic logic [63:0] parent_stride_of(input int d);
        logic [CFG_W-1:0] w;
        w = (d < 2) ? m_str_lo : m_str_hi;
        return (d % 2 == 0) ? 64'(w[63:32]) : 64'(w[31:0]);
    endfunction

    function automatic logic [63:0] elem_bytes_of(input logic [ETYPE_W-1:0] code);
        case (code)
            stwag_pkg::ET_BOOL, stwag_pkg::ET_U8, stwag_pkg::ET_I8:
                return 64'd1;
            stwag_pkg::ET_U16, stwag_pkg::ET_I16:
                return 64'd2;
            stwag_pkg::ET_U32, stwag_pkg::ET_I32, stwag_pkg::ET_F16, stwag_pkg::ET_F32:
                return 64'd4;
            stwag_pkg::ET_U64, stwag_pkg::ET_I64, stwag_pkg::ET_F64:
                return 64'd8;
            default:
                return 64'd0;
        endcase
    endfunction

    // Address of the current element, then advance the odometer
    function automatic t_walk_result walk_step(input logic restart);
        t_walk_result r;
        int           n;
        logic [63:0]  sum, stride, sz, crd, s;
        logic         is_last, done;
        n = (m_num_dims > DEF_MAX_DIMS) ? DEF_MAX_DIMS : int'(m_num_dims);
        if (restart) begin
            for (int d = 0; d < 4; d++) m_coord[d] = '0;
            m_dest = '0;
        end
        // scalar walk: one element, state untouched
        if (n == 0) begin
            r.offset = '0;
            r.dst    = '0;
            r.last   = 1'b1;
            return r;
        end
        sum     = '0;
        stride  = 64'd1;
        is_last = 1'b1;
        for (int d = n - 1; d >= 0; d--) begin
            sz  = lane_of(m_dim_sizes, d);
            crd = 64'(m_coord[d]);
            if (crd + 64'd1 < sz) is_last = 1'b0;
            if (m_view_en) begin
                crd = crd + lane_of(m_view_starts, d);
                s   = parent_stride_of(d);
            end else begin
                s = stride;
            end
            sum    = sum + crd * s;
            stride = stride * sz;
        end
        r.offset = OFF_W'(sum * elem_bytes_of(m_elem_type));
        r.dst    = m_dest;
        r.last   = is_last;
        // innermost active dimension counts first
        done = 1'b0;
        for (int d = n - 1; d >= 0; d--) begin
            if (!done) begin
                if (64'(m_coord[d]) + 64'd1 < lane_of(m_dim_sizes, d)) begin
                    m_coord[d] = m_coord[d] + 1'b1;
                    done = 1'b1;
                end else begin
                    m_coord[d] = '0;
                end
            end
        end
        m_dest = is_last ? '0 : m_dest + 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    // Register write; only issued while the walk is drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_NUM_DIMS:     m_num_dims    = val[NDIM_W-1:0];
            REG_DIM_SIZES:    m_dim_sizes   = val;
            REG_VIEW_ENABLE:  m_view_en     = val[0];
            REG_VIEW_STARTS:  m_view_starts = val;
            REG_STRIDES_LOW:  m_str_lo      = val;
            REG_STRIDES_HIGH: m_str_hi      = val;
            REG_ELEM_TYPE:    m_elem_type   = val[ETYPE_W-1:0];
            default:          ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Sender stops until the pipeline is empty, then lets it settle
    task automatic wait_drained();
        while (restart_queue.size() != 0 || in_valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 2) @(negedge clk);
    endtask

    task automatic walk_items(input int count, input int restart_odds);
        @(posedge clk);
        for (int k = 0; k < count; k++)
            restart_queue.push_back($urandom_range(0, restart_odds - 1) == 0);
        wait_drained();
    endtask

    // Accepted items feed the predictor; accepted results are checked
    always @(posedge clk) begin : accept_side
        t_walk_result e;
        took_item = rst_n && in_valid && !in_stall;
        if (took_item) begin
            pending_results.push_back(walk_step(in_restart));
            n_items++;
        end
        if (rst_n && out_valid && !out_stall) begin
            n_results++;
            if (res_last) n_last++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending, dst_index %0d",
                                          res_dst));
            end else begin
                e = pending_results.pop_front();
                if (res_offset !== e.offset)
                    report_mismatch($sformatf("src_byte_offset %h, expected %h",
                                              res_offset, e.offset));
                if (res_dst !== e.dst)
                    report_mismatch($sformatf("dst_index %0d, expected %0d",
                                              res_dst, e.dst));
                if (res_last !== e.last)
                    report_mismatch($sformatf("last_element %b, expected %b (dst %0d)",
                                              res_last, e.last, e.dst));
            end
        end
    end

    // Item driver: random bursts with random gaps between them
    always @(negedge clk) begin
        if (!in_valid || took_item) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (restart_queue.size() != 0) begin
                in_valid   <= 1'b1;
                in_restart <= restart_queue.pop_front();
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result stall: free-running, random and periodic stretches
    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(10, 80);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= $urandom_range(0, 1);
            default: out_stall <= (cycle_count % 3 == 0);
        endcase
    end

    // Run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        t_walk_result      e;
        logic [NDIM_W-1:0] nd;
        int                nd_pick;
        logic [CFG_W-1:0]  sizes;
        logic [CFG_W-1:0]  r;
        int                items_per_phase;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: one-dimensional walk over a zero-sized dimension
        @(posedge clk);
        restart_queue.push_back(1'b0);
        restart_queue.push_back(1'b1);
        restart_queue.push_back(1'b0);
        wait_drained();

        // Scalar walk
        write_reg(REG_NUM_DIMS, 64'd0);
        @(posedge clk);
        restart_queue.push_back(1'b0);
        restart_queue.push_back(1'b1);
        wait_drained();

        // Too many dimensions taken as four; a zero size in dimension 1
        write_reg(REG_NUM_DIMS, 64'd7);
        write_reg(REG_DIM_SIZES, {16'd1, 16'd0, 16'd2, 16'd3});
        write_reg(REG_ELEM_TYPE, 64'(stwag_pkg::ET_F64));
        walk_items(8, 1 << 30);

        // Shrink sizes without restart so coordinates sit past their size;
        // an undefined element type gives a zero offset
        write_reg(REG_DIM_SIZES, {16'd1, 16'd1, 16'd2, 16'd2});
        write_reg(REG_ELEM_TYPE, 64'd13);
        walk_items(3, 1 << 30);

        // Two active dimensions leave the counters of dimensions 2 and 3 alone; view mode with
        // maximal starts and strides overflows the offset
        write_reg(REG_NUM_DIMS, 64'd2);
        write_reg(REG_VIEW_ENABLE, 64'd1);
        write_reg(REG_VIEW_STARTS, '1);
        write_reg(REG_STRIDES_LOW, '1);
        write_reg(REG_STRIDES_HIGH, '1);
        write_reg(REG_ELEM_TYPE, 64'(stwag_pkg::ET_U64));
        write_reg(REG_UNMAPPED, '1);
        @(posedge clk);
        restart_queue.push_back(1'b0);
        restart_queue.push_back(1'b0);
        restart_queue.push_back(1'b1);
        restart_queue.push_back(1'b0);
        wait_drained();

        // Random phases; phase p sets element type code p, so the phases step through every code
        for (int p = 0; p < N_PHASES; p++) begin
            nd_pick = $urandom_range(0, 9);
            if (nd_pick > 7 || $urandom_range(0, 9) == 0) nd_pick = 1 + p % DEF_MAX_DIMS;
            if (p == N_PHASES - 1) nd_pick = DEF_MAX_DIMS;
            nd = NDIM_W'(nd_pick);
            if ($urandom_range(0, 4) == 0) begin
                sizes = rand64();
            end else begin
                sizes = {16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
                         16'($urandom_range(0, 4)), 16'($urandom_range(0, 4))};
            end
            r = rand64();
            write_reg(REG_NUM_DIMS, {r[63:NDIM_W], nd});
            write_reg(REG_DIM_SIZES, sizes);
            r = rand64();
            write_reg(REG_VIEW_ENABLE, r);
            if ($urandom_range(0, 1) == 0) begin
                write_reg(REG_VIEW_STARTS, rand64());
                write_reg(REG_STRIDES_LOW, rand64());
                write_reg(REG_STRIDES_HIGH, rand64());
            end else begin
                write_reg(REG_VIEW_STARTS, {16'($urandom_range(0, 7)), 16'($urandom_range(0, 7)),
                                            16'($urandom_range(0, 7)), 16'($urandom_range(0, 7))});
                write_reg(REG_STRIDES_LOW, {32'($urandom_range(0, 99)),
                                            32'($urandom_range(0, 99))});
                write_reg(REG_STRIDES_HIGH, {32'($urandom_range(0, 99)),
                                             32'($urandom_range(0, 99))});
            end
            r = rand64();
            write_reg(REG_ELEM_TYPE, {r[63:ETYPE_W], ETYPE_W'(p)});
            items_per_phase = $urandom_range(35, 60);
            walk_items(items_per_phase, 16);
        end

        repeat (4 * PIPE_LAT) @(posedge clk);
        while (pending_results.size() != 0) begin
            e = pending_results.pop_front();
            report_mismatch($sformatf("no result for dst_index %0d", e.dst));
        end

        $display("Walked %0d items in %0d random phases plus directed cases;", n_items, N_PHASES);
        $display("checked %0d results, %0d with last_element set, %0d mismatches.",
                 n_results, n_last, err_count);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
